>>> rtl/slm_pkg.sv
// Shared types and command codes for the sorted list merge block.
`default_nettype none
package slm_pkg;

   // Command codes carried in the request beat
   localparam logic [1:0] CMD_APPEND_A = 2'd0;
   localparam logic [1:0] CMD_APPEND_B = 2'd1;
   localparam logic [1:0] CMD_MERGE    = 2'd2;

   // Request beat
   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] value;
   } req_type;

   // Response beat
   typedef struct packed {
      logic signed [31:0] merged_value;
      logic               last_flag;
   } rsp_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

endpackage
`default_nettype wire

>>> rtl/slm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module slm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/sorted_list_merge.sv
// An append is stored at its accepting edge; an accepted merge enters the merge state and its
// first beat is then registered from the list RAM heads. Requests are held off while a merge
// runs. One append per cycle; a merge gives one beat per cycle for all stored values while the
// output is not stalled, set by the registered list RAM reads (next head from the next index).
// Reset: synchronous; clears both list counts, the controller and the output valid.
// The list RAMs are not cleared; only entries below the counts are ever read.
`default_nettype none
module sorted_list_merge #(
   parameter int DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire slm_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output slm_pkg::rsp_type      rsp_payload
);
   import slm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;
   logic [CW-1:0] idx_a_inc, idx_b_inc;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic        req_beat, ctl_ready, load;
   logic        wr_a, wr_b, have_a, have_b, take_a, last;
   logic [31:0] rd_a, rd_b;

   assign req_beat = req_valid && req_ready;
   assign wr_a = req_beat && (req_payload.command == CMD_APPEND_A) && (cnt_a_ff < CNT_FULL);
   assign wr_b = req_beat && (req_payload.command == CMD_APPEND_B) && (cnt_b_ff < CNT_FULL);

   // List storage
   slm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[AW-1:0]),
      .wr_data (req_payload.value),
      .rd_addr (idx_a_in[AW-1:0]),
      .rd_data (rd_a)
   );

   slm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[AW-1:0]),
      .wr_data (req_payload.value),
      .rd_addr (idx_b_in[AW-1:0]),
      .rd_data (rd_b)
   );

   // Head selection: A wins when strictly smaller or when B is used up; ties go to B
   always_comb begin
      have_a = idx_a_ff < cnt_a_ff;
      have_b = idx_b_ff < cnt_b_ff;
      take_a = have_a && (!have_b || ($signed(rd_a) < $signed(rd_b)));
      idx_a_inc = idx_a_ff + CW'(load && take_a);
      idx_b_inc = idx_b_ff + CW'(load && !take_a);
      last = (idx_a_inc == cnt_a_ff) && (idx_b_inc == cnt_b_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_payload.command == CMD_MERGE) &&
                ((cnt_a_ff != '0) || (cnt_b_ff != '0))) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (load && last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs
   always_comb begin
      ctl_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         ST_IDLE:  ctl_ready = 1'b1;
         ST_MERGE: load = !rsp_valid_ff || rsp_ready;
         default: begin
            ctl_ready = 1'b0;
            load      = 1'b0;
         end
      endcase
   end

   // Counts, read indexes and output register
   always_comb begin
      cnt_a_in = cnt_a_ff + CW'(wr_a);
      cnt_b_in = cnt_b_ff + CW'(wr_b);
      idx_a_in = idx_a_inc;
      idx_b_in = idx_b_inc;
      if (load && last) begin
         cnt_a_in = '0;
         cnt_b_in = '0;
         idx_a_in = '0;
         idx_b_in = '0;
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_data_in.merged_value = take_a ? rd_a : rd_b;
         rsp_data_in.last_flag    = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready   = ctl_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
`default_nettype wire

>>> rtl/slm_checker.sv
// Port-level assertions for the sorted list merge block, bound to the top level.
`default_nettype none
module slm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire slm_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire slm_pkg::rsp_type rsp_payload
);
   import slm_pkg::*;

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A waiting request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("waiting request beat changed");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response beat changed");

   // New response beats come only from a running merge
   a_rsp_from_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> !$past(req_ready))
      else $error("response beat appeared while no merge was running");

   // Until the last beat is produced, requests are held off
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_flag |-> !req_ready)
      else $error("request accepted in the middle of a merge run");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
